// ----- hw/rtl/battery_ratio_window_average_assert.svh -----
// Assertion macros shared by the battery ratio window average block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef BATTERY_RATIO_WINDOW_AVERAGE_ASSERT_SVH
`define BATTERY_RATIO_WINDOW_AVERAGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRWA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRWA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/brwa_pkg.sv -----
`default_nettype none

package brwa_pkg;

	localparam int SAMPLE_W = 16;
	localparam int VOLTS_W = 24;
	localparam int BIT_CNT_W = $clog2(VOLTS_W);

	// Combined gain 3.709 * 1.75 = 25963 / 4000; 2^16 / 4000 reduces to 2^11 / 125.
	localparam int unsigned GAIN_NUM = 25963;
	localparam int GAIN_NUM_W = 15;
	localparam int unsigned GAIN_DEN = 125;
	localparam int GAIN_DEN_W = 7;
	localparam int FRAC_SHIFT = 11;

	localparam logic [VOLTS_W-1:0] VOLTS_MAX = {VOLTS_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL1,
		ST_MUL2,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/brwa_if.sv -----
`default_nettype none

interface brwa_in_if;
	logic valid;
	logic ready;
	logic [brwa_pkg::SAMPLE_W-1:0] battery_sample;
	logic [brwa_pkg::SAMPLE_W-1:0] reference_sample;

	modport source (output valid, output battery_sample, output reference_sample,
		input ready);
	modport sink (input valid, input battery_sample, input reference_sample,
		output ready);
endinterface

interface brwa_out_if;
	logic valid;
	logic ready;
	logic [brwa_pkg::VOLTS_W-1:0] battery_volts;
	logic divide_error;

	modport source (output valid, output battery_volts, output divide_error,
		input ready);
	modport sink (input valid, input battery_volts, input divide_error,
		output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/brwa_ram.sv -----
`default_nettype none

module brwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/battery_ratio_window_average.sv -----
// An accepted item passes the read, two multiply and prepare states, then the 24-step
// bit-serial divider, which is skipped when the reference window is empty or the ratio
// saturates. Items are taken only in the idle state, after the last result is loaded.
// A result waits in the output register while the next item is taken and worked on.
// Reset (arst_n low) clears both windows through per-entry valid bits, the slot
// pointer, the sums and counts, the state machine and the output valid flag.
`default_nettype none

`include "battery_ratio_window_average_assert.svh"

module battery_ratio_window_average #(
	parameter int WINDOW_LENGTH = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	brwa_in_if.sink    samples,
	brwa_out_if.source result
);

	localparam int SMW = brwa_pkg::SAMPLE_W;
	localparam int QW = brwa_pkg::VOLTS_W;
	localparam int FR = brwa_pkg::FRAC_SHIFT;
	localparam int PW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	localparam int CW = $clog2(WINDOW_LENGTH + 1);
	localparam int SW = SMW + CW;
	localparam int P1W = SW + CW;
	localparam int MW = P1W + brwa_pkg::GAIN_NUM_W;
	localparam int NUMW = MW + FR;
	localparam int DENW = P1W + brwa_pkg::GAIN_DEN_W;
	localparam int NW = NUMW + 1;
	localparam int CMPW = (NW > DENW + QW) ? NW : DENW + QW;

	brwa_pkg::state_t state_q, state_d;

	logic [PW-1:0]            ptr_q;
	logic [WINDOW_LENGTH-1:0] valid_q;
	logic [SW-1:0]            bsum_q, rsum_q;
	logic [CW-1:0]            bcnt_q, rcnt_q;
	logic                     out_valid_q;
	logic [QW-1:0]            volts_q;
	logic                     err_out_q;

	logic [SMW-1:0]           bat_q, ref_q;
	logic [P1W-1:0]           p1_q, d1_q;
	logic [NUMW-1:0]          num_q;
	logic [DENW-1:0]          den_q;
	logic                     err_q, sat_q;
	logic [DENW-1:0]          rem_q;
	logic [QW-1:0]            quo_q;
	logic [brwa_pkg::BIT_CNT_W-1:0] bit_q;

	logic                     accept;
	logic                     load_out;
	logic [2*SMW-1:0]         ram_rdata;
	logic [SMW-1:0]           old_bat, old_ref;
	logic [CW-1:0]            bcount;
	logic [MW-1:0]            num_prod;
	logic [NW-1:0]            n_full;
	logic                     sat;
	logic [DENW:0]            trial;
	logic                     trial_ge;

	assign accept = samples.valid && samples.ready;
	assign samples.ready = (state_q == brwa_pkg::ST_IDLE);
	assign load_out = (state_q == brwa_pkg::ST_DONE) && (!out_valid_q || result.ready);

	assign result.valid = out_valid_q;
	assign result.battery_volts = volts_q;
	assign result.divide_error = err_out_q;

	brwa_ram #(
		.WIDTH(2 * SMW),
		.DEPTH(WINDOW_LENGTH)
	) u_window (
		.clk  (clk),
		.we   (state_q == brwa_pkg::ST_READ),
		.waddr(ptr_q),
		.wdata({bat_q, ref_q}),
		.re   (accept),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	// An entry never written since reset reads as zero.
	assign old_bat = valid_q[ptr_q] ? ram_rdata[2*SMW-1:SMW] : '0;
	assign old_ref = valid_q[ptr_q] ? ram_rdata[SMW-1:0] : '0;

	// An empty battery window counts as one entry.
	assign bcount = (bcnt_q == '0) ? CW'(1) : bcnt_q;

	assign num_prod = MW'(p1_q) * MW'(brwa_pkg::GAIN_NUM);

	// Rounding half up: add half the divisor before the truncating division.
	assign n_full = NW'(num_q) + NW'(den_q >> 1);
	assign sat = CMPW'(n_full) >= CMPW'({den_q, {QW{1'b0}}});

	assign trial = {rem_q, quo_q[QW-1]};
	assign trial_ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brwa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			brwa_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = brwa_pkg::ST_READ;
				end
			end
			brwa_pkg::ST_READ: state_d = brwa_pkg::ST_MUL1;
			brwa_pkg::ST_MUL1: state_d = brwa_pkg::ST_MUL2;
			brwa_pkg::ST_MUL2: state_d = brwa_pkg::ST_PREP;
			brwa_pkg::ST_PREP: begin
				if (err_q || sat) begin
					state_d = brwa_pkg::ST_DONE;
				end else begin
					state_d = brwa_pkg::ST_DIV;
				end
			end
			brwa_pkg::ST_DIV: begin
				if (bit_q == '0) begin
					state_d = brwa_pkg::ST_DONE;
				end
			end
			brwa_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = brwa_pkg::ST_IDLE;
				end
			end
			default: state_d = brwa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			valid_q <= '0;
			bsum_q <= '0;
			rsum_q <= '0;
			bcnt_q <= '0;
			rcnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == brwa_pkg::ST_READ) begin
				bsum_q <= bsum_q - SW'(old_bat) + SW'(bat_q);
				rsum_q <= rsum_q - SW'(old_ref) + SW'(ref_q);
				bcnt_q <= bcnt_q - CW'(old_bat != '0) + CW'(bat_q != '0);
				rcnt_q <= rcnt_q - CW'(old_ref != '0) + CW'(ref_q != '0);
				valid_q[ptr_q] <= 1'b1;
				if (ptr_q == PW'(WINDOW_LENGTH - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + PW'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			brwa_pkg::ST_IDLE: begin
				bat_q <= samples.battery_sample;
				ref_q <= samples.reference_sample;
			end
			brwa_pkg::ST_MUL1: begin
				p1_q <= P1W'(bsum_q) * P1W'(rcnt_q);
				d1_q <= P1W'(bcount) * P1W'(rsum_q);
				err_q <= (rcnt_q == '0) || (rsum_q == '0);
			end
			brwa_pkg::ST_MUL2: begin
				num_q <= {num_prod, {FR{1'b0}}};
				den_q <= DENW'(d1_q) * DENW'(brwa_pkg::GAIN_DEN);
			end
			brwa_pkg::ST_PREP: begin
				sat_q <= sat;
				// Below the saturation bound the upper part is already smaller than den.
				rem_q <= DENW'(n_full >> QW);
				quo_q <= n_full[QW-1:0];
				bit_q <= brwa_pkg::BIT_CNT_W'(QW - 1);
			end
			brwa_pkg::ST_DIV: begin
				rem_q <= trial_ge ? DENW'(trial - {1'b0, den_q}) : DENW'(trial);
				quo_q <= {quo_q[QW-2:0], trial_ge};
				bit_q <= bit_q - brwa_pkg::BIT_CNT_W'(1);
			end
			brwa_pkg::ST_DONE: begin
				if (load_out) begin
					err_out_q <= err_q;
					if (err_q) begin
						volts_q <= '0;
					end else if (sat_q) begin
						volts_q <= brwa_pkg::VOLTS_MAX;
					end else begin
						volts_q <= quo_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	`BRWA_ASSERT_SAME(a_ref_empty_match, 1'b1, (rcnt_q == '0) == (rsum_q == '0), "reference count and sum disagree on an empty window")
	`BRWA_ASSERT_SAME(a_bat_empty_match, 1'b1, (bcnt_q == '0) == (bsum_q == '0), "battery count and sum disagree on an empty window")
	`BRWA_ASSERT_SAME(a_count_bound, 1'b1, (bcnt_q <= CW'(WINDOW_LENGTH)) && (rcnt_q <= CW'(WINDOW_LENGTH)), "nonzero count exceeds window length")
	`BRWA_ASSERT_NEXT(a_accept_reads, accept, state_q == brwa_pkg::ST_READ, "accepted item did not start a window read")
	`BRWA_ASSERT_NEXT(a_div_ends, (state_q == brwa_pkg::ST_DIV) && (bit_q == '0), state_q == brwa_pkg::ST_DONE, "divider ran past its last quotient bit")
	`BRWA_ASSERT_SAME(a_err_zero, out_valid_q && err_out_q, volts_q == '0, "error result carries a nonzero voltage")

endmodule

`default_nettype wire
